### design/assert_macros.svh
// Assertion helpers shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every edge outside reset.
`define VCA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define VCA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define VCA_ASSERT(label, clk, rst, prop, msg)
`define VCA_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### design/vca_pkg.sv
package vca_pkg;

   // Default geometry
   localparam int NUM_CHANNELS_DEF = 8;
   localparam int HANDLE_BITS_DEF  = 16;

   // Port field widths
   localparam int FUNC_W   = 3;
   localparam int SOUND_W  = 8;
   localparam int TARGET_W = 16;
   localparam int MASK_W   = 8;
   localparam int ACTION_W = 3;
   localparam int CHAN_W   = 3;
   localparam int NEWH_W   = 16;
   localparam int STATUS_W = 2;

   // Slots of the scan record: channel indexes
   localparam int IDX_SLOTS  = 5;
   localparam int SLOT_FREE  = 0;
   localparam int SLOT_SAME  = 1;
   localparam int SLOT_LOOP  = 2;
   localparam int SLOT_ANY   = 3;
   localparam int SLOT_MATCH = 4;

   // Slots of the scan record: best handles so far
   localparam int H_SLOTS    = 3;
   localparam int HSLOT_SAME = 0;
   localparam int HSLOT_LOOP = 1;
   localparam int HSLOT_ANY  = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PLAY   = 3'd0,
      FUNC_STOP   = 3'd1,
      FUNC_PAUSE  = 3'd2,
      FUNC_RESUME = 3'd3,
      FUNC_QUERY  = 3'd4,
      FUNC_FINISH = 3'd5
   } func_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE   = 3'd0,
      ACT_START  = 3'd1,
      ACT_HALT   = 3'd2,
      ACT_PAUSE  = 3'd3,
      ACT_RESUME = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_STOPPED = 2'd0,
      STAT_PAUSED  = 2'd1,
      STAT_PLAYING = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PLAY,
      OP_CLEAR,
      OP_SET_PAUSE,
      OP_CLR_PAUSE,
      OP_FINISH
   } cell_op_type;

   // Hit flags carried along the cell chain
   typedef struct packed {
      logic free_hit;
      logic same_hit;
      logic loop_hit;
      logic any_hit;
      logic match_hit;
      logic match_paused;
   } scan_flags_type;

   // Update command broadcast to all cells
   typedef struct packed {
      cell_op_type op;
      logic        loop_flag;
   } upd_type;

endpackage

### design/vca_cell.sv
`include "assert_macros.svh"

module vca_cell #(
   parameter int NUM_CHANNELS = vca_pkg::NUM_CHANNELS_DEF,
   parameter int HANDLE_BITS  = vca_pkg::HANDLE_BITS_DEF,
   parameter int CELL_IDX     = 0,
   localparam int IDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  logic                                                clock,
   input  logic                                                reset,
   // scan record from the left neighbor
   input  logic                                                in_valid,
   input  vca_pkg::scan_flags_type                             in_flags,
   input  logic [vca_pkg::IDX_SLOTS-1:0][IDX_W-1:0]            in_idx,
   input  logic [vca_pkg::H_SLOTS-1:0][HANDLE_BITS-1:0]        in_h,
   // search key
   input  logic [vca_pkg::SOUND_W-1:0]                         key_sound,
   input  logic [vca_pkg::TARGET_W-1:0]                        key_target,
   // update broadcast
   input  vca_pkg::upd_type                                    upd,
   input  logic [IDX_W-1:0]                                    upd_idx,
   input  logic [HANDLE_BITS-1:0]                              upd_handle,
   input  logic [vca_pkg::SOUND_W-1:0]                         upd_sound,
   input  logic [vca_pkg::MASK_W-1:0]                          upd_mask,
   // scan record to the right neighbor
   output logic                                                out_valid,
   output vca_pkg::scan_flags_type                             out_flags,
   output logic [vca_pkg::IDX_SLOTS-1:0][IDX_W-1:0]            out_idx,
   output logic [vca_pkg::H_SLOTS-1:0][HANDLE_BITS-1:0]        out_h
);
   import vca_pkg::*;

   localparam int CMP_W           = (HANDLE_BITS > TARGET_W) ? HANDLE_BITS : TARGET_W;
   localparam int MB              = CELL_IDX % MASK_W;
   localparam bit HAS_BIT         = (CELL_IDX < MASK_W);
   localparam logic [IDX_W-1:0] ME = IDX_W'(CELL_IDX);

   // channel state
   logic                   busy_ff, busy_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [SOUND_W-1:0]     sound_ff, sound_in;
   logic                   loop_ff, loop_in;
   logic                   paused_ff, paused_in;

   // scan record stage
   logic                                   valid_ff;
   scan_flags_type                         flags_ff, flags_in;
   logic [IDX_SLOTS-1:0][IDX_W-1:0]        idx_ff, idx_in;
   logic [H_SLOTS-1:0][HANDLE_BITS-1:0]    h_ff, h_in;

   logic sel;
   logic hit_match;

   assign sel = (upd_idx == ME);
   assign hit_match = busy_ff && (key_target != '0) &&
                      (CMP_W'(handle_ff) == CMP_W'(key_target));

   // merge this channel into the passing record
   always_comb begin
      flags_in = in_flags;
      idx_in   = in_idx;
      h_in     = in_h;
      if (!in_flags.free_hit && !busy_ff) begin
         flags_in.free_hit = 1'b1;
         idx_in[SLOT_FREE] = ME;
      end
      if (busy_ff && (sound_ff == key_sound) &&
          (!in_flags.same_hit || (handle_ff < in_h[HSLOT_SAME]))) begin
         flags_in.same_hit = 1'b1;
         idx_in[SLOT_SAME] = ME;
         h_in[HSLOT_SAME]  = handle_ff;
      end
      if (busy_ff && loop_ff &&
          (!in_flags.loop_hit || (handle_ff < in_h[HSLOT_LOOP]))) begin
         flags_in.loop_hit = 1'b1;
         idx_in[SLOT_LOOP] = ME;
         h_in[HSLOT_LOOP]  = handle_ff;
      end
      if (busy_ff && (!in_flags.any_hit || (handle_ff < in_h[HSLOT_ANY]))) begin
         flags_in.any_hit = 1'b1;
         idx_in[SLOT_ANY] = ME;
         h_in[HSLOT_ANY]  = handle_ff;
      end
      if (!in_flags.match_hit && hit_match) begin
         flags_in.match_hit    = 1'b1;
         flags_in.match_paused = paused_ff;
         idx_in[SLOT_MATCH]    = ME;
      end
   end

   // apply broadcast updates
   always_comb begin
      busy_in   = busy_ff;
      handle_in = handle_ff;
      sound_in  = sound_ff;
      loop_in   = loop_ff;
      paused_in = paused_ff;
      unique case (upd.op)
         OP_PLAY: begin
            if (sel) begin
               busy_in   = 1'b1;
               handle_in = upd_handle;
               sound_in  = upd_sound;
               loop_in   = upd.loop_flag;
               paused_in = 1'b0;
            end
         end
         OP_CLEAR: begin
            if (sel) begin
               busy_in   = 1'b0;
               handle_in = '0;
               sound_in  = '0;
               loop_in   = 1'b0;
               paused_in = 1'b0;
            end
         end
         OP_SET_PAUSE: begin
            if (sel) begin
               paused_in = 1'b1;
            end
         end
         OP_CLR_PAUSE: begin
            if (sel) begin
               paused_in = 1'b0;
            end
         end
         OP_FINISH: begin
            // channels past the mask width count as still playing
            if (HAS_BIT && !upd_mask[MB]) begin
               busy_in   = 1'b0;
               handle_in = '0;
               sound_in  = '0;
               loop_in   = 1'b0;
               paused_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         handle_ff <= '0;
         sound_ff  <= '0;
         loop_ff   <= 1'b0;
         paused_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         handle_ff <= handle_in;
         sound_ff  <= sound_in;
         loop_ff   <= loop_in;
         paused_ff <= paused_in;
         valid_ff  <= in_valid;
      end
   end

   // record payload
   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      idx_ff   <= idx_in;
      h_ff     <= h_in;
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_idx   = idx_ff;
   assign out_h     = h_ff;

   `VCA_ASSERT(a_busy_handle_nonzero, clock, reset, busy_ff |-> (handle_ff != '0), "busy channel holds handle zero")
   `VCA_ASSERT_NEVER(a_idle_paused, clock, reset, !busy_ff && paused_ff, "idle channel marked paused")
   `VCA_ASSERT(a_play_sets_busy, clock, reset, (upd.op == OP_PLAY && sel) |=> busy_ff, "play did not claim channel")

endmodule

### design/vca_ctrl.sv
`include "assert_macros.svh"

module vca_ctrl #(
   parameter int NUM_CHANNELS = vca_pkg::NUM_CHANNELS_DEF,
   parameter int HANDLE_BITS  = vca_pkg::HANDLE_BITS_DEF,
   localparam int IDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // command channel
   input  logic                                       start,
   output logic                                       busy,
   input  logic [vca_pkg::FUNC_W-1:0]                 req_func,
   input  logic [vca_pkg::SOUND_W-1:0]                req_sound_id,
   input  logic                                       req_loop_request,
   input  logic [vca_pkg::TARGET_W-1:0]               req_target_handle,
   input  logic [vca_pkg::MASK_W-1:0]                 req_playing_mask,
   // chain head and tail
   output logic                                       launch,
   output logic [vca_pkg::SOUND_W-1:0]                key_sound,
   output logic [vca_pkg::TARGET_W-1:0]               key_target,
   input  logic                                       tail_valid,
   input  vca_pkg::scan_flags_type                    tail_flags,
   input  logic [vca_pkg::IDX_SLOTS-1:0][IDX_W-1:0]   tail_idx,
   // update broadcast
   output vca_pkg::upd_type                           upd,
   output logic [IDX_W-1:0]                           upd_idx,
   output logic [HANDLE_BITS-1:0]                     upd_handle,
   output logic [vca_pkg::SOUND_W-1:0]                upd_sound,
   output logic [vca_pkg::MASK_W-1:0]                 upd_mask,
   // result channel
   output logic                                       rsp_valid,
   output logic [vca_pkg::ACTION_W-1:0]               rsp_action,
   output logic [vca_pkg::CHAN_W-1:0]                 rsp_channel_index,
   output logic [vca_pkg::NEWH_W-1:0]                 rsp_new_handle,
   output logic                                       rsp_stole_channel,
   output logic [vca_pkg::STATUS_W-1:0]               rsp_sound_status,
   output logic                                       rsp_handle_unknown
);
   import vca_pkg::*;

   state_type state_ff, state_in;
   logic      launch_ff, launch_in;
   logic      accept;
   logic      decide;

   // latched item
   func_type               func_ff;
   logic [SOUND_W-1:0]     sound_ff;
   logic                   loop_ff;
   logic [TARGET_W-1:0]    target_ff;
   logic [MASK_W-1:0]      mask_ff;

   logic [HANDLE_BITS-1:0] cnt_ff, cnt_in, cnt_next;

   // decision
   action_type             act;
   logic [IDX_W-1:0]       chosen;
   logic [HANDLE_BITS-1:0] nh;
   logic                   stole;
   status_type             status;
   logic                   unknown;
   cell_op_type            op;
   logic [IDX_W+CHAN_W-1:0]       chan_ext;
   logic [HANDLE_BITS+NEWH_W-1:0] nh_ext;

   // result registers
   logic                   rsp_valid_ff;
   action_type             rsp_action_ff;
   logic [CHAN_W-1:0]      rsp_chan_ff;
   logic [NEWH_W-1:0]      rsp_nh_ff;
   logic                   rsp_stole_ff;
   status_type             rsp_status_ff;
   logic                   rsp_unknown_ff;

   assign accept = start && !busy;
   assign decide = (state_ff == ST_SCAN) && tail_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      busy      = 1'b0;
      launch_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: launch_in = start;
         ST_SCAN: busy = 1'b1;
         default: busy = 1'b0;
      endcase
   end

   // next handle: wraps past zero
   always_comb begin
      cnt_next = cnt_ff + 1'b1;
      if (cnt_next == '0) begin
         cnt_next = HANDLE_BITS'(1);
      end
   end

   // result and update once the record leaves the last cell
   always_comb begin
      act     = ACT_NONE;
      chosen  = '0;
      nh      = '0;
      stole   = 1'b0;
      status  = STAT_STOPPED;
      unknown = 1'b0;
      op      = OP_NONE;
      cnt_in  = cnt_ff;
      if (decide) begin
         unique case (func_ff) inside
            FUNC_PLAY: begin
               if (tail_flags.free_hit) begin
                  chosen = tail_idx[SLOT_FREE];
               end else begin
                  stole = 1'b1;
                  if (tail_flags.same_hit) begin
                     chosen = tail_idx[SLOT_SAME];
                  end else if (tail_flags.loop_hit) begin
                     chosen = tail_idx[SLOT_LOOP];
                  end else begin
                     chosen = tail_idx[SLOT_ANY];
                  end
               end
               act    = ACT_START;
               nh     = cnt_next;
               cnt_in = cnt_next;
               op     = OP_PLAY;
            end
            FUNC_STOP, FUNC_PAUSE, FUNC_RESUME: begin
               if (!tail_flags.match_hit) begin
                  unknown = 1'b1;
               end else if (func_ff == FUNC_STOP) begin
                  chosen = tail_idx[SLOT_MATCH];
                  act    = ACT_HALT;
                  op     = OP_CLEAR;
               end else if (func_ff == FUNC_PAUSE) begin
                  if (!tail_flags.match_paused) begin
                     chosen = tail_idx[SLOT_MATCH];
                     act    = ACT_PAUSE;
                     op     = OP_SET_PAUSE;
                  end
               end else begin
                  if (tail_flags.match_paused) begin
                     chosen = tail_idx[SLOT_MATCH];
                     act    = ACT_RESUME;
                     op     = OP_CLR_PAUSE;
                  end
               end
            end
            FUNC_QUERY: begin
               if (tail_flags.match_hit) begin
                  status = tail_flags.match_paused ? STAT_PAUSED : STAT_PLAYING;
               end
            end
            FUNC_FINISH: op = OP_FINISH;
            default: begin
            end
         endcase
      end
   end

   assign chan_ext = (IDX_W+CHAN_W)'(chosen);
   assign nh_ext   = (HANDLE_BITS+NEWH_W)'(nh);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= decide;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= func_type'(req_func);
         sound_ff  <= req_sound_id;
         loop_ff   <= req_loop_request;
         target_ff <= req_target_handle;
         mask_ff   <= req_playing_mask;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (decide) begin
         rsp_action_ff  <= act;
         rsp_chan_ff    <= chan_ext[CHAN_W-1:0];
         rsp_nh_ff      <= nh_ext[NEWH_W-1:0];
         rsp_stole_ff   <= stole;
         rsp_status_ff  <= status;
         rsp_unknown_ff <= unknown;
      end
   end

   assign launch     = launch_ff;
   assign key_sound  = sound_ff;
   assign key_target = target_ff;

   assign upd.op        = op;
   assign upd.loop_flag = loop_ff;
   assign upd_idx       = chosen;
   assign upd_handle    = cnt_next;
   assign upd_sound     = sound_ff;
   assign upd_mask      = mask_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_channel_index  = rsp_chan_ff;
   assign rsp_new_handle     = rsp_nh_ff;
   assign rsp_stole_channel  = rsp_stole_ff;
   assign rsp_sound_status   = rsp_status_ff;
   assign rsp_handle_unknown = rsp_unknown_ff;

   `VCA_ASSERT(a_tail_in_scan, clock, reset, tail_valid |-> (state_ff == ST_SCAN), "scan record arrived while idle")
   `VCA_ASSERT(a_rsp_after_scan, clock, reset, rsp_valid_ff |-> $past(decide), "result without finished scan")
   `VCA_ASSERT(a_play_handle, clock, reset, (rsp_valid_ff && rsp_action_ff == ACT_START) |-> (rsp_nh_ff != '0 || HANDLE_BITS > NEWH_W), "play issued handle zero")
   `VCA_ASSERT_NEVER(a_steal_start, clock, reset, rsp_valid_ff && rsp_stole_ff && rsp_action_ff != ACT_START, "steal without start")
   `VCA_ASSERT_NEVER(a_unknown_none, clock, reset, rsp_valid_ff && rsp_unknown_ff && rsp_action_ff != ACT_NONE, "unknown handle with an action")

endmodule

### design/voice_channel_allocator.sv
// Voice channel allocator. A command is taken when start is high and busy is low; every
// command gives exactly one result, shown for a single cycle with rsp_valid high, and the
// receiver cannot hold it off. Channel state lives in a row of NUM_CHANNELS cells; a scan
// record walks the row one cell per cycle to find the free, same-sound, looping,
// lowest-handle and handle-matched channels, then the controller broadcasts the update.
// From accept to result a command passes the launch register, the register of each cell
// in turn and the result register, and busy drops in time for the next command to be
// accepted on the cycle its result is shown. Play steals a channel when none is free and
// reports it with rsp_stole_channel; the halt of the old sound is implied.
module voice_channel_allocator #(
   parameter int NUM_CHANNELS = vca_pkg::NUM_CHANNELS_DEF,
   parameter int HANDLE_BITS  = vca_pkg::HANDLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [vca_pkg::FUNC_W-1:0]      req_func,
   input  logic [vca_pkg::SOUND_W-1:0]     req_sound_id,
   input  logic                            req_loop_request,
   input  logic [vca_pkg::TARGET_W-1:0]    req_target_handle,
   input  logic [vca_pkg::MASK_W-1:0]      req_playing_mask,
   output logic                            rsp_valid,
   output logic [vca_pkg::ACTION_W-1:0]    rsp_action,
   output logic [vca_pkg::CHAN_W-1:0]      rsp_channel_index,
   output logic [vca_pkg::NEWH_W-1:0]      rsp_new_handle,
   output logic                            rsp_stole_channel,
   output logic [vca_pkg::STATUS_W-1:0]    rsp_sound_status,
   output logic                            rsp_handle_unknown
);
   import vca_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // scan chain links
   logic                                chain_valid [NUM_CHANNELS+1];
   scan_flags_type                      chain_flags [NUM_CHANNELS+1];
   logic [IDX_SLOTS-1:0][IDX_W-1:0]     chain_idx   [NUM_CHANNELS+1];
   logic [H_SLOTS-1:0][HANDLE_BITS-1:0] chain_h     [NUM_CHANNELS+1];

   logic               launch;
   logic [SOUND_W-1:0] key_sound;
   logic [TARGET_W-1:0] key_target;

   upd_type                upd;
   logic [IDX_W-1:0]       upd_idx;
   logic [HANDLE_BITS-1:0] upd_handle;
   logic [SOUND_W-1:0]     upd_sound;
   logic [MASK_W-1:0]      upd_mask;

   // empty record enters at the head
   assign chain_valid[0] = launch;
   assign chain_flags[0] = '0;
   assign chain_idx[0]   = '0;
   assign chain_h[0]     = '0;

   vca_ctrl #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .HANDLE_BITS  (HANDLE_BITS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_sound_id       (req_sound_id),
      .req_loop_request   (req_loop_request),
      .req_target_handle  (req_target_handle),
      .req_playing_mask   (req_playing_mask),
      .launch             (launch),
      .key_sound          (key_sound),
      .key_target         (key_target),
      .tail_valid         (chain_valid[NUM_CHANNELS]),
      .tail_flags         (chain_flags[NUM_CHANNELS]),
      .tail_idx           (chain_idx[NUM_CHANNELS]),
      .upd                (upd),
      .upd_idx            (upd_idx),
      .upd_handle         (upd_handle),
      .upd_sound          (upd_sound),
      .upd_mask           (upd_mask),
      .rsp_valid          (rsp_valid),
      .rsp_action         (rsp_action),
      .rsp_channel_index  (rsp_channel_index),
      .rsp_new_handle     (rsp_new_handle),
      .rsp_stole_channel  (rsp_stole_channel),
      .rsp_sound_status   (rsp_sound_status),
      .rsp_handle_unknown (rsp_handle_unknown)
   );

   // one cell per channel
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
      vca_cell #(
         .NUM_CHANNELS (NUM_CHANNELS),
         .HANDLE_BITS  (HANDLE_BITS),
         .CELL_IDX     (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (chain_valid[i]),
         .in_flags   (chain_flags[i]),
         .in_idx     (chain_idx[i]),
         .in_h       (chain_h[i]),
         .key_sound  (key_sound),
         .key_target (key_target),
         .upd        (upd),
         .upd_idx    (upd_idx),
         .upd_handle (upd_handle),
         .upd_sound  (upd_sound),
         .upd_mask   (upd_mask),
         .out_valid  (chain_valid[i+1]),
         .out_flags  (chain_flags[i+1]),
         .out_idx    (chain_idx[i+1]),
         .out_h      (chain_h[i+1])
      );
   end

endmodule
